[hw/rtl/jmhp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmhp_pkg - shared types and constants of the JPEG marker header parser
// Parse phases, result kinds, marker codes, queue sizing and the result record.
// ----------------------------------------------------------------------------
package jmhp_pkg;

    localparam logic [7:0] MARK_FILL = 8'hFF;
    localparam logic [7:0] MARK_SOF0 = 8'hC0;
    localparam logic [7:0] MARK_SOF2 = 8'hC2;
    localparam logic [7:0] MARK_DQT  = 8'hDB;
    localparam logic [7:0] MARK_SOS  = 8'hDA;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [5:0] QUANT_LAST = 6'd63;

    localparam logic [2:0] KIND_FRAME_HDR  = 3'd0;
    localparam logic [2:0] KIND_FRAME_COMP = 3'd1;
    localparam logic [2:0] KIND_QUANT      = 3'd2;
    localparam logic [2:0] KIND_SCAN_COMP  = 3'd3;
    localparam logic [2:0] KIND_SCAN_PARAM = 3'd4;
    localparam logic [2:0] KIND_ENTROPY    = 3'd5;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_SOF_HDR,
        PH_SOF_COMP,
        PH_DQT_HDR,
        PH_DQT_TBL,
        PH_SOS_HDR,
        PH_SOS_COMP,
        PH_SOS_TAIL,
        PH_SKIP_HUNT,
        PH_SKIP_SCAN,
        PH_ENTROPY
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  count;
        logic [3:0]  high_nibble;
        logic [3:0]  low_nibble;
        logic [7:0]  table_select;
        logic [5:0]  quant_index;
        logic [15:0] quant_value;
        logic        segment_end;
    } t_result;

endpackage

[hw/rtl/jpeg_marker_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_header_parser - JPEG marker segment parser, top level
// Parses SOF0/SOF2, DQT and SOS headers and streams unstuffed entropy bytes.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_ready      i_data_byte, i_final_byte
//   out      output     o_out_valid / i_out_ready    o_kind .. o_segment_end
//
// One byte per cycle while the queue has space; each byte is parsed by the
// front state machine, which sets the rate.
// A result is written into the queue at the edge that accepts its byte, and
// from there it is loaded into the output register.
// Results pass a four-entry queue and an output register.
// Reset is synchronous, active low: parser back to marker hunt, queue emptied.
// Input stalls only while the queue is full.
// ----------------------------------------------------------------------------
module jpeg_marker_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_height,
    output logic [15:0] o_width,
    output logic [7:0]  o_count,
    output logic [3:0]  o_high_nibble,
    output logic [3:0]  o_low_nibble,
    output logic [7:0]  o_table_select,
    output logic [5:0]  o_quant_index,
    output logic [15:0] o_quant_value,
    output logic        o_segment_end
);

    logic              q_space;
    logic              q_push;
    logic              q_pop;
    logic              q_avail;
    jmhp_pkg::t_result f_result;
    jmhp_pkg::t_result q_item;
    jmhp_pkg::t_result out_item;

    assign o_in_ready = q_space;

    jmhp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_space      (q_space),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (q_push),
        .o_result     (f_result)
    );

    jmhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_result),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    jmhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_item      (out_item)
    );

    assign o_kind         = out_item.kind;
    assign o_byte_value   = out_item.byte_value;
    assign o_height       = out_item.height;
    assign o_width        = out_item.width;
    assign o_count        = out_item.count;
    assign o_high_nibble  = out_item.high_nibble;
    assign o_low_nibble   = out_item.low_nibble;
    assign o_table_select = out_item.table_select;
    assign o_quant_index  = out_item.quant_index;
    assign o_quant_value  = out_item.quant_value;
    assign o_segment_end  = out_item.segment_end;

endmodule

[hw/rtl/jmhp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmhp_front - byte parser
// Takes one file byte per request, walks the marker segments and pushes at
// most one result record into the queue for each byte.
// ----------------------------------------------------------------------------
module jmhp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_space,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    output logic             o_push,
    output jmhp_pkg::t_result o_result
);

    jmhp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_seg_left, n_seg_left;
    logic [2:0]  r_step, n_step;
    logic [7:0]  r_items, n_items;
    logic [5:0]  r_entry, n_entry;
    logic [7:0]  r_tbl_hdr, n_tbl_hdr;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_held2, n_held2;
    logic [7:0]  r_prec, n_prec;
    logic [15:0] r_height, n_height;
    logic [15:0] r_width, n_width;
    logic        r_after_ff, n_after_ff;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] seg_dec;
    logic [15:0] seg_len;
    logic [15:0] seg_set;
    logic [7:0]  items_dec;
    jmhp_pkg::t_result res;
    logic        emit;

    assign accept  = i_in_valid && i_space;
    assign b       = i_data_byte;
    assign seg_dec = (r_seg_left != 16'd0) ? r_seg_left - 16'd1 : r_seg_left;
    assign seg_len = {r_held, b};
    assign seg_set = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
    assign items_dec = r_items - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= jmhp_pkg::PH_HUNT;
            r_seg_left <= '0;
            r_step     <= '0;
            r_items    <= '0;
            r_entry    <= '0;
            r_tbl_hdr  <= '0;
            r_held     <= '0;
            r_held2    <= '0;
            r_prec     <= '0;
            r_height   <= '0;
            r_width    <= '0;
            r_after_ff <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_seg_left <= n_seg_left;
            r_step     <= n_step;
            r_items    <= n_items;
            r_entry    <= n_entry;
            r_tbl_hdr  <= n_tbl_hdr;
            r_held     <= n_held;
            r_held2    <= n_held2;
            r_prec     <= n_prec;
            r_height   <= n_height;
            r_width    <= n_width;
            r_after_ff <= n_after_ff;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_seg_left = r_seg_left;
        n_step     = r_step;
        n_items    = r_items;
        n_entry    = r_entry;
        n_tbl_hdr  = r_tbl_hdr;
        n_held     = r_held;
        n_held2    = r_held2;
        n_prec     = r_prec;
        n_height   = r_height;
        n_width    = r_width;
        n_after_ff = r_after_ff;
        res        = '0;
        emit       = 1'b0;

        unique case (r_phase)
            jmhp_pkg::PH_HUNT: begin
                if (r_after_ff) begin
                    n_after_ff = 1'b0;
                    n_step     = '0;
                    if (b == jmhp_pkg::MARK_SOF0 || b == jmhp_pkg::MARK_SOF2) begin
                        n_phase = jmhp_pkg::PH_SOF_HDR;
                    end else if (b == jmhp_pkg::MARK_DQT) begin
                        n_phase = jmhp_pkg::PH_DQT_HDR;
                    end else if (b == jmhp_pkg::MARK_SOS) begin
                        n_phase = jmhp_pkg::PH_SOS_HDR;
                    end else begin
                        n_after_ff = (b == jmhp_pkg::MARK_FILL);
                    end
                end else begin
                    n_after_ff = (b == jmhp_pkg::MARK_FILL);
                end
            end
            jmhp_pkg::PH_SOF_HDR: begin
                if (r_step == 3'd0) begin
                    n_held = b;
                    n_step = 3'd1;
                end else if (r_step == 3'd1) begin
                    n_seg_left = seg_set;
                    n_step     = 3'd2;
                end else begin
                    n_seg_left = seg_dec;
                    n_step     = r_step + 3'd1;
                    case (r_step)
                        3'd2: n_prec   = b;
                        3'd3: n_height = {b, 8'h00};
                        3'd4: n_height = r_height | {8'h00, b};
                        3'd5: n_width  = {b, 8'h00};
                        3'd6: n_width  = r_width | {8'h00, b};
                        default: begin
                            emit            = 1'b1;
                            res.kind        = jmhp_pkg::KIND_FRAME_HDR;
                            res.byte_value  = r_prec;
                            res.height      = r_height;
                            res.width       = r_width;
                            res.count       = b;
                            res.segment_end = (b == 8'd0);
                            n_items         = b;
                            n_step          = '0;
                            if (b == 8'd0) begin
                                n_phase = (seg_dec != 16'd0) ? jmhp_pkg::PH_SKIP_HUNT
                                                             : jmhp_pkg::PH_HUNT;
                            end else begin
                                n_phase = jmhp_pkg::PH_SOF_COMP;
                            end
                        end
                    endcase
                end
            end
            jmhp_pkg::PH_SOF_COMP: begin
                n_seg_left = seg_dec;
                if (r_step == 3'd0) begin
                    n_held = b;
                    n_step = 3'd1;
                end else if (r_step == 3'd1) begin
                    n_held2 = b;
                    n_step  = 3'd2;
                end else begin
                    emit             = 1'b1;
                    res.kind         = jmhp_pkg::KIND_FRAME_COMP;
                    res.byte_value   = r_held;
                    res.high_nibble  = r_held2[7:4];
                    res.low_nibble   = r_held2[3:0];
                    res.table_select = b;
                    res.segment_end  = (r_items == 8'd1);
                    n_items          = items_dec;
                    n_step           = '0;
                    if (items_dec == 8'd0) begin
                        n_phase = (seg_dec != 16'd0) ? jmhp_pkg::PH_SKIP_HUNT
                                                     : jmhp_pkg::PH_HUNT;
                    end
                end
            end
            jmhp_pkg::PH_DQT_HDR: begin
                if (r_step == 3'd0) begin
                    n_held = b;
                    n_step = 3'd1;
                end else begin
                    n_seg_left = seg_set;
                    n_step     = '0;
                    n_phase    = (seg_set != 16'd0) ? jmhp_pkg::PH_DQT_TBL
                                                    : jmhp_pkg::PH_HUNT;
                end
            end
            jmhp_pkg::PH_DQT_TBL: begin
                n_seg_left = seg_dec;
                if (r_step == 3'd0) begin
                    n_tbl_hdr = b;
                    n_entry   = '0;
                    n_step    = 3'd1;
                end else if (r_step == 3'd1 && r_tbl_hdr[7:4] != 4'd0) begin
                    n_held = b;
                    n_step = 3'd2;
                end else begin
                    emit            = 1'b1;
                    res.kind        = jmhp_pkg::KIND_QUANT;
                    res.high_nibble = r_tbl_hdr[7:4];
                    res.low_nibble  = r_tbl_hdr[3:0];
                    res.quant_index = r_entry;
                    res.quant_value = (r_step == 3'd2) ? {r_held, b} : {8'h00, b};
                    res.segment_end = (seg_dec == 16'd0);
                    n_step          = (r_entry == jmhp_pkg::QUANT_LAST) ? 3'd0 : 3'd1;
                    n_entry         = r_entry + 6'd1;
                end
                if (seg_dec == 16'd0) begin
                    n_phase = jmhp_pkg::PH_HUNT;
                    n_step  = '0;
                end
            end
            jmhp_pkg::PH_SOS_HDR: begin
                if (r_step == 3'd0) begin
                    n_held = b;
                    n_step = 3'd1;
                end else if (r_step == 3'd1) begin
                    n_seg_left = seg_set;
                    n_step     = 3'd2;
                end else begin
                    n_seg_left = seg_dec;
                    n_items    = b;
                    n_step     = '0;
                    n_phase    = (b == 8'd0) ? jmhp_pkg::PH_SOS_TAIL
                                             : jmhp_pkg::PH_SOS_COMP;
                end
            end
            jmhp_pkg::PH_SOS_COMP: begin
                n_seg_left = seg_dec;
                if (r_step == 3'd0) begin
                    n_held = b;
                    n_step = 3'd1;
                end else begin
                    emit            = 1'b1;
                    res.kind        = jmhp_pkg::KIND_SCAN_COMP;
                    res.byte_value  = r_held;
                    res.high_nibble = b[7:4];
                    res.low_nibble  = b[3:0];
                    n_items         = items_dec;
                    n_step          = '0;
                    if (items_dec == 8'd0) begin
                        n_phase = jmhp_pkg::PH_SOS_TAIL;
                    end
                end
            end
            jmhp_pkg::PH_SOS_TAIL: begin
                n_seg_left = seg_dec;
                if (r_step == 3'd0) begin
                    n_held = b;
                    n_step = 3'd1;
                end else if (r_step == 3'd1) begin
                    n_held2 = b;
                    n_step  = 3'd2;
                end else begin
                    emit            = 1'b1;
                    res.kind        = jmhp_pkg::KIND_SCAN_PARAM;
                    res.byte_value  = r_held;
                    res.count       = r_held2;
                    res.high_nibble = b[7:4];
                    res.low_nibble  = b[3:0];
                    res.segment_end = 1'b1;
                    n_after_ff      = 1'b0;
                    n_step          = '0;
                    n_phase         = (seg_dec != 16'd0) ? jmhp_pkg::PH_SKIP_SCAN
                                                         : jmhp_pkg::PH_ENTROPY;
                end
            end
            jmhp_pkg::PH_SKIP_HUNT,
            jmhp_pkg::PH_SKIP_SCAN: begin
                n_seg_left = seg_dec;
                if (seg_dec == 16'd0) begin
                    n_phase    = (r_phase == jmhp_pkg::PH_SKIP_SCAN) ? jmhp_pkg::PH_ENTROPY
                                                                     : jmhp_pkg::PH_HUNT;
                    n_after_ff = 1'b0;
                end
            end
            jmhp_pkg::PH_ENTROPY: begin
                if (r_after_ff) begin
                    if (b == jmhp_pkg::BYTE_ZERO) begin
                        emit           = 1'b1;
                        res.kind       = jmhp_pkg::KIND_ENTROPY;
                        res.byte_value = jmhp_pkg::MARK_FILL;
                        n_after_ff     = 1'b0;
                    end else if (b != jmhp_pkg::MARK_FILL) begin
                        n_after_ff = 1'b0;
                        n_step     = '0;
                        if (b == jmhp_pkg::MARK_SOF0 || b == jmhp_pkg::MARK_SOF2) begin
                            n_phase = jmhp_pkg::PH_SOF_HDR;
                        end else if (b == jmhp_pkg::MARK_DQT) begin
                            n_phase = jmhp_pkg::PH_DQT_HDR;
                        end else if (b == jmhp_pkg::MARK_SOS) begin
                            n_phase = jmhp_pkg::PH_SOS_HDR;
                        end else begin
                            n_phase = jmhp_pkg::PH_HUNT;
                        end
                    end
                end else if (b == jmhp_pkg::MARK_FILL) begin
                    n_after_ff = 1'b1;
                end else begin
                    emit           = 1'b1;
                    res.kind       = jmhp_pkg::KIND_ENTROPY;
                    res.byte_value = b;
                end
            end
            default: begin
                n_phase    = jmhp_pkg::PH_HUNT;
                n_after_ff = 1'b0;
                n_step     = '0;
            end
        endcase

        if (i_final_byte) begin
            n_phase    = jmhp_pkg::PH_HUNT;
            n_after_ff = 1'b0;
            n_step     = '0;
        end
    end

    assign o_push   = accept && emit;
    assign o_result = res;

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_in_valid && i_space)
        else $error("result pushed without an accepted byte");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_result.kind <= jmhp_pkg::KIND_ENTROPY)
        else $error("result kind out of range");

endmodule

[hw/rtl/jmhp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmhp_queue - result queue
// Short first-in first-out buffer that decouples the parser from the output.
// ----------------------------------------------------------------------------
module jmhp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jmhp_pkg::t_result i_item,
    output logic              o_space,
    input  logic              i_pop,
    output logic              o_avail,
    output jmhp_pkg::t_result o_item
);

    jmhp_pkg::t_result r_mem [jmhp_pkg::Q_DEPTH];
    logic [jmhp_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [jmhp_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [jmhp_pkg::Q_CNT_W-1:0] r_count, n_count;

    localparam logic [jmhp_pkg::Q_PTR_W-1:0] PTR_LAST =
        jmhp_pkg::Q_PTR_W'(jmhp_pkg::Q_DEPTH - 1);
    localparam logic [jmhp_pkg::Q_PTR_W-1:0] PTR_ONE =
        jmhp_pkg::Q_PTR_W'(1);
    localparam logic [jmhp_pkg::Q_CNT_W-1:0] CNT_FULL =
        jmhp_pkg::Q_CNT_W'(jmhp_pkg::Q_DEPTH);
    localparam logic [jmhp_pkg::Q_CNT_W-1:0] CNT_ONE =
        jmhp_pkg::Q_CNT_W'(1);

    assign o_space = (r_count != CNT_FULL);
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

[hw/rtl/jmhp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmhp_back - output stage
// Pops result records from the queue into the output register and holds
// each one until the downstream side takes it.
// ----------------------------------------------------------------------------
module jmhp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  jmhp_pkg::t_result i_item,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output jmhp_pkg::t_result o_item
);

    logic              r_valid;
    jmhp_pkg::t_result r_item;

    assign o_pop       = i_avail && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule
